FILE: rtl/core/msmp_pkg.sv
// Package for the multi-source sum/mean/product combiner.
// Register indexes, combine modes, field widths and controller interface structs.
// No dependencies.
package msmp_pkg;

  localparam int MAX_SOURCES_DEFAULT = 8;

  localparam int IDX_FIELD_W = 3;
  localparam int VAL_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int USE_W       = 4;
  localparam int MODE_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAN_FORCES_NAN = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SUM     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRODUCT = 2'd2;

  localparam logic [USE_W-1:0] SOURCES_IN_USE_RESET = 4'd1;

  typedef struct packed {
    logic wr;
    logic start;
    logic accum;
    logic mul_fix;
    logic next;
    logic div_start;
    logic div_step;
    logic load_out;
  } msmp_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic all_pub;
    logic used_zero;
    logic slot_nan_cur;
    logic mode_prod;
    logic mode_mean;
    logic walk_last;
    logic result_nan;
    logic div_done;
    logic out_free;
  } msmp_status_t;

endpackage

FILE: rtl/core/msmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/msmp_ctrl.sv
// Controller state machine for the combiner: sequences update, slot walk,
// divide and result load. Depends on msmp_pkg.
module msmp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  msmp_pkg::msmp_status_t st,
  output msmp_pkg::msmp_cmd_t    cmd
);
  import msmp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr     = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!st.idx_ok || !st.all_pub) begin
          state_next = S_IDLE;
        end else begin
          cmd.start  = 1'b1;
          state_next = st.used_zero ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (!st.slot_nan_cur && st.mode_prod) begin
          state_next = S_MUL2;
        end else if (st.walk_last) begin
          state_next = S_FIN;
        end else begin
          cmd.next   = 1'b1;
          state_next = S_RD;
        end
      end
      S_MUL2: begin
        cmd.mul_fix = 1'b1;
        if (st.walk_last) begin
          state_next = S_FIN;
        end else begin
          cmd.next   = 1'b1;
          state_next = S_RD;
        end
      end
      S_FIN: begin
        if (!st.result_nan && st.mode_mean) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/msmp_dp.sv
// Datapath for the combiner: configuration registers, slot store, accumulator,
// Q16.16 multiplier, serial divider and output register.
// Depends on msmp_pkg and msmp_ram.
module msmp_dp #(
  parameter int MAX_SOURCES = msmp_pkg::MAX_SOURCES_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [msmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [msmp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [msmp_pkg::IDX_FIELD_W-1:0]       source_index,
  input  logic signed [msmp_pkg::VAL_W-1:0]      reading_value,
  input  logic                                   reading_is_nan,
  input  msmp_pkg::msmp_cmd_t                    cmd,
  output msmp_pkg::msmp_status_t                 st,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [msmp_pkg::VAL_W-1:0]      combined_value,
  output logic                                   combined_is_nan,
  output logic                                   combined_saturated
);
  import msmp_pkg::*;

  localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
  localparam int ACC_W  = VAL_W + $clog2(MAX_SOURCES) + 1;
  localparam int DCNT_W = $clog2(ACC_W + 1);
  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] Q_ONE   = ACC_W'(64'sd65536);

  logic [USE_W-1:0]    sources_in_use;
  logic [MODE_W-1:0]   combine_mode;
  logic                nan_forces_nan;

  logic [MAX_SOURCES-1:0] published;
  logic [MAX_SOURCES-1:0] slot_nan;
  logic [MAX_SOURCES-1:0] in_use;

  logic                   idx_ok;
  logic [CNT_W-1:0]       used;
  logic [IDX_W-1:0]       walk;
  logic [CNT_W-1:0]       count;
  logic                   any_nan;
  logic                   sat;
  logic signed [ACC_W-1:0] acc;
  logic signed [63:0]     prod;
  logic signed [63:0]     prod_sh;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [VAL_W-1:0] acc32;

  logic [ACC_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W:0]         rem_sh;
  logic [DCNT_W-1:0]      dcnt;

  logic signed [VAL_W-1:0] sum_clamped;
  logic                    sum_sat;
  logic [VAL_W-1:0]        mean_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      sources_in_use <= SOURCES_IN_USE_RESET;
      combine_mode   <= MODE_SUM;
      nan_forces_nan <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCES_IN_USE: sources_in_use <= cfg_data;
        CFG_COMBINE_MODE:   combine_mode   <= cfg_data[MODE_W-1:0];
        CFG_NAN_FORCES_NAN: nan_forces_nan <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(sources_in_use) > MAX_SOURCES) begin
      used = CNT_W'(MAX_SOURCES);
    end else begin
      used = CNT_W'(sources_in_use);
    end
    for (int j = 0; j < MAX_SOURCES; j++) begin
      in_use[j] = (j < 32'(used));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      published <= '0;
      slot_nan  <= '0;
    end else if (cmd.wr) begin
      for (int j = 0; j < MAX_SOURCES; j++) begin
        if (j == 32'(source_index)) begin
          published[j] <= 1'b1;
          slot_nan[j]  <= reading_is_nan;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      idx_ok <= (32'(source_index) < MAX_SOURCES);
    end
  end

  msmp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_SOURCES)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.wr && (32'(source_index) < MAX_SOURCES)),
    .waddr (IDX_W'(source_index)),
    .wdata (reading_value),
    .raddr (walk),
    .rdata (rd_val)
  );

  assign acc32   = acc[VAL_W-1:0];
  assign prod_sh = prod >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      walk    <= '0;
      count   <= '0;
      any_nan <= 1'b0;
      sat     <= 1'b0;
      acc     <= (combine_mode == MODE_PRODUCT) ? Q_ONE : '0;
    end else begin
      if (cmd.next) begin
        walk <= walk + 1'b1;
      end
      if (cmd.accum) begin
        if (slot_nan[walk]) begin
          any_nan <= 1'b1;
        end else begin
          count <= count + 1'b1;
          if (combine_mode == MODE_PRODUCT) begin
            prod <= acc32 * rd_val;
          end else begin
            acc <= acc + {{(ACC_W-VAL_W){rd_val[VAL_W-1]}}, rd_val};
          end
        end
      end
      if (cmd.mul_fix) begin
        if (prod_sh > 64'sd2147483647) begin
          acc <= SUM_MAX;
          sat <= 1'b1;
        end else if (prod_sh < -64'sd2147483648) begin
          acc <= SUM_MIN;
          sat <= 1'b1;
        end else begin
          acc <= ACC_W'(prod_sh);
        end
      end
    end
  end

  // restoring divide of |acc| by count, one quotient bit a cycle
  assign rem_sh = {rem, quo[ACC_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo  <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      rem  <= '0;
      dcnt <= DCNT_W'(ACC_W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (rem_sh >= {1'b0, count}) begin
        rem <= CNT_W'(rem_sh - {1'b0, count});
        quo <= {quo[ACC_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        quo <= {quo[ACC_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sum_sat = 1'b1;
    if (acc > SUM_MAX) begin
      sum_clamped = SUM_MAX[VAL_W-1:0];
    end else if (acc < SUM_MIN) begin
      sum_clamped = SUM_MIN[VAL_W-1:0];
    end else begin
      sum_clamped = acc32;
      sum_sat     = 1'b0;
    end
    mean_val = acc[ACC_W-1] ? (~quo[VAL_W-1:0] + 1'b1) : quo[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (st.result_nan) begin
        combined_value     <= '0;
        combined_is_nan    <= 1'b1;
        combined_saturated <= 1'b0;
      end else begin
        combined_is_nan <= 1'b0;
        if (st.mode_mean) begin
          combined_value     <= mean_val;
          combined_saturated <= 1'b0;
        end else if (st.mode_prod) begin
          combined_value     <= acc32;
          combined_saturated <= sat;
        end else begin
          combined_value     <= sum_clamped;
          combined_saturated <= sum_sat;
        end
      end
    end
  end

  always_comb begin
    st.idx_ok       = idx_ok;
    st.all_pub      = &(published | ~in_use);
    st.used_zero    = (used == '0);
    st.slot_nan_cur = slot_nan[walk];
    st.mode_prod    = (combine_mode == MODE_PRODUCT);
    st.mode_mean    = (combine_mode == MODE_MEAN);
    st.walk_last    = (32'(walk) == 32'(used) - 32'd1);
    st.result_nan   = (any_nan && nan_forces_nan) || (count == '0);
    st.div_done     = (dcnt == '0);
    st.out_free     = !out_valid || !out_stall;
  end

endmodule

FILE: rtl/core/multi_source_sum_mean_product.sv
// Top level of the multi-source sum/mean/product combiner.
// Depends on msmp_pkg, msmp_ctrl and msmp_dp.
//
// Keeps the latest Q16.16 reading of each sensor slot and, once every slot in
// use has published, answers each update with the sum, mean or product of the
// valid readings. Updates are taken one at a time: an update that yields no
// result ends after the check; otherwise a walk over the slots in use follows,
// each slot read and then accumulated (a non-NaN slot in product mode adds a
// rescale/clamp step after the multiply), then a finish step and the load of
// the output register. Mean adds a bit-serial divide before the load.
// The output register may hold a result while the next update is accepted.
// The configuration port is always ready; write it only while the block is idle.
module multi_source_sum_mean_product #(
  parameter int MAX_SOURCES = msmp_pkg::MAX_SOURCES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msmp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msmp_pkg::IDX_FIELD_W-1:0]  source_index,
  input  logic signed [msmp_pkg::VAL_W-1:0] reading_value,
  input  logic                              reading_is_nan,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [msmp_pkg::VAL_W-1:0] combined_value,
  output logic                              combined_is_nan,
  output logic                              combined_saturated
);
  import msmp_pkg::*;

  msmp_cmd_t    cmd;
  msmp_status_t st;

  assign cfg_ready = 1'b1;

  msmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  msmp_dp #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .source_index       (source_index),
    .reading_value      (reading_value),
    .reading_is_nan     (reading_is_nan),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .combined_value     (combined_value),
    .combined_is_nan    (combined_is_nan),
    .combined_saturated (combined_saturated)
  );

endmodule

FILE: rtl/core/msmp_checker.sv
// Port-level checker for the combiner, bound to the top level.
// Depends on msmp_pkg for field widths.
module msmp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [msmp_pkg::VAL_W-1:0] combined_value,
  input logic                              combined_is_nan,
  input logic                              combined_saturated
);

  // a NaN result carries a zero value and no saturation
  a_nan_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && combined_is_nan |-> combined_value == '0 && !combined_saturated)
    else $error("NaN result with non-zero value or saturation");

  // one update at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transaction");

  // a result needs at least the check cycle after its update
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared in the cycle after an input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(combined_value)
      && $stable(combined_is_nan) && $stable(combined_saturated))
    else $error("stalled result changed");

endmodule

bind multi_source_sum_mean_product msmp_checker u_msmp_checker (.*);
